// ===== sv/clre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clre_pkg
// Shared types and codes for the circular linked ring engine: operation codes,
// controller states, and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package clre_pkg;

  // Width of the operation field.
  localparam int unsigned OP_BITS = 3;

  // Operation codes; the remaining codes are ignored.
  typedef enum logic [OP_BITS-1:0] {
    OP_LOAD       = 3'd0,
    OP_INS_AFTER  = 3'd1,
    OP_INS_BEFORE = 3'd2,
    OP_DEL_AFTER  = 3'd3,
    OP_DEL_BEFORE = 3'd4
  } op_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FETCH = 2'd1,
    ST_WRITE = 2'd2,
    ST_HOLD  = 2'd3
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // Capture the item and read both tables at the station.
    logic fetch;     // Capture the neighbor, read at it, do the first writes.
    logic finish;    // Do the second writes and update the ring ends.
    logic load_out;  // Move the neighbor into the output register.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_result;  // The held operation returns a neighbor.
  } sts_t;

endpackage

// ===== sv/clre_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clre_datapath
// Link tables, item registers, ring end registers and the neighbor output
// register. Each table has one write port and one registered read port.
// ----------------------------------------------------------------------------
module clre_datapath #(
  parameter int unsigned ID_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  clre_pkg::cmd_t               cmd_i,
  output clre_pkg::sts_t               sts_o,
  input  logic [clre_pkg::OP_BITS-1:0] op_i,
  input  logic [ID_BITS-1:0]           station_i,
  input  logic [ID_BITS-1:0]           new_station_i,
  output logic [ID_BITS-1:0]           neighbor_o
);

  localparam int unsigned Depth = 1 << ID_BITS;

  // Link tables.
  logic [ID_BITS-1:0] next_mem [Depth];
  logic [ID_BITS-1:0] prev_mem [Depth];

  // Item and working registers.
  clre_pkg::op_e      op_q;
  logic [ID_BITS-1:0] stn_q;
  logic [ID_BITS-1:0] new_q;
  logic [ID_BITS-1:0] nb_q;
  logic [ID_BITS-1:0] next_rd_q;
  logic [ID_BITS-1:0] prev_rd_q;
  logic [ID_BITS-1:0] neighbor_q;

  // Ring ends.
  logic [ID_BITS-1:0] first_q, first_d;
  logic [ID_BITS-1:0] last_q, last_d;
  logic               nonempty_q, nonempty_d;

  // Read and write controls.
  logic               after_w;
  logic [ID_BITS-1:0] rd_link_w;
  logic [ID_BITS-1:0] rd_addr;
  logic               rd_en;
  logic               nx_we, pv_we;
  logic [ID_BITS-1:0] nx_addr, nx_data, pv_addr, pv_data;

  // Remove/insert after follow the next links, the others the previous links.
  assign after_w   = (op_q == clre_pkg::OP_INS_AFTER) || (op_q == clre_pkg::OP_DEL_AFTER);
  assign rd_link_w = after_w ? next_rd_q : prev_rd_q;
  assign rd_addr   = cmd_i.fetch ? rd_link_w : station_i;
  assign rd_en     = cmd_i.accept | cmd_i.fetch;

  // Write ports and ring end updates for both passes, in the operation's order.
  always_comb begin
    nx_we      = 1'b0;
    nx_addr    = stn_q;
    nx_data    = new_q;
    pv_we      = 1'b0;
    pv_addr    = stn_q;
    pv_data    = new_q;
    first_d    = first_q;
    last_d     = last_q;
    nonempty_d = nonempty_q;
    if (cmd_i.fetch) begin
      unique case (op_q)
        clre_pkg::OP_LOAD: begin
          if (nonempty_q) begin
            nx_we   = 1'b1;
            nx_addr = last_q;
            nx_data = stn_q;
            pv_we   = 1'b1;
            pv_addr = stn_q;
            pv_data = last_q;
          end
        end
        clre_pkg::OP_INS_AFTER: begin
          nx_we   = 1'b1;
          nx_addr = stn_q;
          nx_data = new_q;
          pv_we   = 1'b1;
          pv_addr = rd_link_w;
          pv_data = new_q;
        end
        clre_pkg::OP_INS_BEFORE: begin
          pv_we   = 1'b1;
          pv_addr = stn_q;
          pv_data = new_q;
          nx_we   = 1'b1;
          nx_addr = rd_link_w;
          nx_data = new_q;
        end
        default: begin
        end
      endcase
    end else if (cmd_i.finish) begin
      unique case (op_q)
        clre_pkg::OP_LOAD: begin
          nx_we   = 1'b1;
          nx_addr = stn_q;
          pv_we   = 1'b1;
          last_d  = stn_q;
          if (nonempty_q) begin
            nx_data = first_q;
            pv_addr = first_q;
            pv_data = stn_q;
          end else begin
            nx_data    = stn_q;
            pv_addr    = stn_q;
            pv_data    = stn_q;
            first_d    = stn_q;
            nonempty_d = 1'b1;
          end
        end
        clre_pkg::OP_INS_AFTER: begin
          nx_we   = 1'b1;
          nx_addr = new_q;
          nx_data = nb_q;
          pv_we   = 1'b1;
          pv_addr = new_q;
          pv_data = stn_q;
        end
        clre_pkg::OP_INS_BEFORE: begin
          pv_we   = 1'b1;
          pv_addr = new_q;
          pv_data = nb_q;
          nx_we   = 1'b1;
          nx_addr = new_q;
          nx_data = stn_q;
        end
        clre_pkg::OP_DEL_AFTER: begin
          nx_we   = 1'b1;
          nx_addr = stn_q;
          nx_data = next_rd_q;
          pv_we   = 1'b1;
          pv_addr = next_rd_q;
          pv_data = stn_q;
        end
        clre_pkg::OP_DEL_BEFORE: begin
          pv_we   = 1'b1;
          pv_addr = stn_q;
          pv_data = prev_rd_q;
          nx_we   = 1'b1;
          nx_addr = prev_rd_q;
          nx_data = stn_q;
        end
        default: begin
        end
      endcase
    end
  end

  // Next link table.
  always_ff @(posedge clk_i) begin
    if (nx_we) begin
      next_mem[nx_addr] <= nx_data;
    end
    if (rd_en) begin
      next_rd_q <= next_mem[rd_addr];
    end
  end

  // Previous link table.
  always_ff @(posedge clk_i) begin
    if (pv_we) begin
      prev_mem[pv_addr] <= pv_data;
    end
    if (rd_en) begin
      prev_rd_q <= prev_mem[rd_addr];
    end
  end

  // Item, neighbor and output registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= clre_pkg::op_e'(op_i);
      stn_q <= station_i;
      new_q <= new_station_i;
    end
    if (cmd_i.fetch) begin
      nb_q <= rd_link_w;
    end
    if (cmd_i.load_out) begin
      neighbor_q <= nb_q;
    end
  end

  // Ring end registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q    <= '0;
      last_q     <= '0;
      nonempty_q <= 1'b0;
    end else begin
      first_q    <= first_d;
      last_q     <= last_d;
      nonempty_q <= nonempty_d;
    end
  end

  assign sts_o.has_result = (op_q == clre_pkg::OP_INS_AFTER)
                         || (op_q == clre_pkg::OP_INS_BEFORE)
                         || (op_q == clre_pkg::OP_DEL_AFTER)
                         || (op_q == clre_pkg::OP_DEL_BEFORE);
  assign neighbor_o = neighbor_q;

endmodule

// ===== sv/clre_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clre_ctrl
// Controller: sequences one item through accept, fetch and write steps and
// owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module clre_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  clre_pkg::sts_t sts_i,
  output clre_pkg::cmd_t cmd_o
);

  clre_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= clre_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      clre_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = clre_pkg::ST_FETCH;
        end
      end
      clre_pkg::ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = clre_pkg::ST_WRITE;
      end
      clre_pkg::ST_WRITE: begin
        cmd_o.finish = 1'b1;
        if (!sts_i.has_result) begin
          state_d = clre_pkg::ST_IDLE;
        end else if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = clre_pkg::ST_IDLE;
        end else begin
          state_d = clre_pkg::ST_HOLD;
        end
      end
      clre_pkg::ST_HOLD: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = clre_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = clre_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid: set on a new result, cleared once the transfer completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/circular_linked_ring_engine_unit.sv =====
`timescale 1ns / 1ps
// After the input transfer the item goes through the fetch and write steps; its
// result enters the output register in the write step, or from hold while the
// output stalls. Items are taken one at a time, as set by the single write port
// of each link table (two writes per table) and the dependent second read of
// removes. A waiting result does not block the next input until its write step.
// Reset clears the ring ends and control; link tables hold no reset value.
// ----------------------------------------------------------------------------
// circular_linked_ring_engine_unit
// Circular doubly linked ring of node ids with append, insert and remove.
// ----------------------------------------------------------------------------
module circular_linked_ring_engine_unit #(
  parameter int unsigned ID_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [clre_pkg::OP_BITS-1:0] op_i,
  input  logic [ID_BITS-1:0]           station_i,
  input  logic [ID_BITS-1:0]           new_station_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ID_BITS-1:0]           neighbor_o
);

  clre_pkg::cmd_t cmd;
  clre_pkg::sts_t sts;

  // Sequencer.
  clre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Link tables and registers.
  clre_datapath #(
    .ID_BITS (ID_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (op_i),
    .station_i     (station_i),
    .new_station_i (new_station_i),
    .neighbor_o    (neighbor_o)
  );

endmodule
